// ----- src/gdpp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gdpp_pkg: shared codes for the grid shortest-path planner
// Opcodes, result status codes, cell search status codes, cost limits and
// configuration register indexes.
// ----------------------------------------------------------------------------
package gdpp_pkg;

    localparam int COST_W = 20;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_PLAN = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    localparam logic [1:0] RS_OK        = 2'd0;
    localparam logic [1:0] RS_NOPATH    = 2'd1;
    localparam logic [1:0] RS_EXHAUSTED = 2'd2;

    localparam logic [1:0] CS_UNV  = 2'd0;
    localparam logic [1:0] CS_FREE = 2'd1;
    localparam logic [1:0] CS_VIS  = 2'd2;
    localparam logic [1:0] CS_BLK  = 2'd3;

    localparam logic [COST_W-1:0] COST_INF = 20'hFFFFF;
    localparam logic [COST_W-1:0] COST_MAX = 20'hFFFFE;

    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_WSTART = 2'd1;
    localparam logic [1:0] REG_WSTEP  = 2'd2;

    localparam logic [8:0] LEN_MAX = 9'd511;

endpackage
`default_nettype wire

// ----- src/grid_dijkstra_path_planner_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// grid_dijkstra_path_planner_unit: Dijkstra planner over an 8-connected grid
// Loads obstacle cells, plans a least-cost path (full grid or windowed
// segments toward waypoints) and returns the path cells from the destination
// back to the start.
// ----------------------------------------------------------------------------
//  Channel   | Signals                                   | Moves
//  ----------+-------------------------------------------+--------------------
//  command   | i_valid / o_ready, i_opcode .. i_dest_col | one beat per item
//  result    | o_valid / i_ready, o_status .. o_last_cell| one beat per item
//  config    | psel penable pwrite paddr pwdata prdata   | APB write / read
//
//  Sequence: a load answers through the result state; a read goes through
//  S_RDWT first when more cells remain. A plan first sweeps the node memory
//  (one entry a cycle), then repeats a minimum scan (one cell read per cycle
//  over the grid or the window) and a relaxation of up to 8 neighbours per
//  extracted cell, then walks the parent chain back from the destination.
//  Reset: after reset the obstacle map is swept to free, one entry a cycle,
//  while no command beat is taken.
//  Stalls: a finished result waits in S_RESP; the block goes back to idle
//  once the result register is free.
// ----------------------------------------------------------------------------
module grid_dijkstra_path_planner_unit #(
    parameter int GRID_ROWS      = 16,
    parameter int GRID_COLS      = 16,
    parameter int COST_FRAC_BITS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // command channel
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [3:0]  i_cell_row,
    input  wire logic [3:0]  i_cell_col,
    input  wire logic        i_cell_blocked,
    input  wire logic [3:0]  i_start_row,
    input  wire logic [3:0]  i_start_col,
    input  wire logic [3:0]  i_dest_row,
    input  wire logic [3:0]  i_dest_col,
    // result channel
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_status,
    output logic [8:0]       o_path_length,
    output logic [3:0]       o_out_row,
    output logic [3:0]       o_out_col,
    output logic             o_last_cell,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int RB        = $clog2(GRID_ROWS);
    localparam int CB        = $clog2(GRID_COLS);
    localparam int AW        = RB + CB;
    localparam int NCELLS    = GRID_ROWS * GRID_COLS;
    localparam int CNTW      = $clog2(NCELLS + 1);
    localparam int MAX_ALPHA = (GRID_ROWS > GRID_COLS) ? GRID_ROWS : GRID_COLS;
    localparam int AL        = $clog2(MAX_ALPHA + 32);
    localparam int SW        = AL + 2;
    localparam int DW        = 2 * SW + 3;
    localparam int LIMIT     = 2 * NCELLS + 2 * MAX_ALPHA + 4;
    localparam int GW        = $clog2(LIMIT + 2);
    localparam int CW        = gdpp_pkg::COST_W;

    localparam logic [CW-1:0] COST_ONE  = CW'(1 << COST_FRAC_BITS);
    localparam logic [CW-1:0] COST_DIAG = CW'((362 << COST_FRAC_BITS) >> 8);
    localparam logic signed [SW-1:0] ROWS_S = SW'(GRID_ROWS);
    localparam logic signed [SW-1:0] COLS_S = SW'(GRID_COLS);

    typedef struct packed {
        logic [1:0]    st;
        logic [CW-1:0] cost;
        logic [AW-1:0] par;
    } t_node;

    typedef enum logic [4:0] {
        S_MAPCLR, S_IDLE, S_RESP, S_PCLR, S_SEED, S_WP, S_PINIT, S_PICK,
        S_PLAST, S_PDONE, S_EXRD, S_EXCAP, S_RISS, S_RWR, S_BTRD, S_BTCHK,
        S_RDWT
    } t_state;

    // lattice / neighbour offsets, index 0..8 row-major over a 3x3 block
    function automatic logic signed [1:0] off_r(input logic [3:0] li);
        logic signed [1:0] v;
        case (li)
            4'd0, 4'd1, 4'd2: v = -2'sd1;
            4'd3, 4'd4, 4'd5: v = 2'sd0;
            default:          v = 2'sd1;
        endcase
        return v;
    endfunction

    function automatic logic signed [1:0] off_c(input logic [3:0] li);
        logic signed [1:0] v;
        case (li)
            4'd0, 4'd3, 4'd6: v = -2'sd1;
            4'd1, 4'd4, 4'd7: v = 2'sd0;
            default:          v = 2'sd1;
        endcase
        return v;
    endfunction

    // ---------------- memories
    t_node         node_mem [1 << AW];
    logic          map_mem  [1 << AW];
    t_node         r_node_q;
    logic          r_map_q;
    logic          node_we, map_we, map_wdata;
    logic [AW-1:0] node_waddr, node_raddr, map_waddr, map_raddr;
    t_node         node_wdata;

    always_ff @(posedge i_clk) begin
        if (node_we) begin
            node_mem[node_waddr] <= node_wdata;
        end
        r_node_q <= node_mem[node_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (map_we) begin
            map_mem[map_waddr] <= map_wdata;
        end
        r_map_q <= map_mem[map_raddr];
    end

    // ---------------- registers
    t_state        r_state;
    logic          r_mode;
    logic [4:0]    r_wstart, r_wstep;
    logic [AW-1:0] r_addr;
    logic [3:0]    r_sr, r_sc, r_tr, r_tc;
    logic [RB-1:0] r_cur_r, r_dest_r;
    logic [CB-1:0] r_cur_c, r_dest_c;
    logic          r_cur_none;
    logic          r_dest_blk, r_found, r_seg_end;
    logic [AL-1:0] r_alpha;
    logic [4:0]    r_step;
    logic [GW-1:0] r_guard;
    logic [AW-1:0] r_wp, r_wres;
    logic          r_wmoved;
    logic signed [DW-1:0] r_wbest;
    logic [3:0]    r_k;
    logic [RB:0]   r_r0, r_r1;
    logic [CB:0]   r_c0, r_c1;
    logic [RB-1:0] r_pr;
    logic [CB-1:0] r_pc;
    logic          r_pk_v;
    logic [AW-1:0] r_pk_addr;
    logic          r_best_none;
    logic [AW-1:0] r_best_addr, r_best_par;
    logic [CW-1:0] r_best_cost;
    logic [CW-1:0] r_cc_cost;
    logic [AW-1:0] r_cc_par;
    logic [AW-1:0] r_nb_addr;
    logic          r_nb_diag;
    logic [AW-1:0] r_x;
    logic [CNTW-1:0] r_n, r_count, r_left;
    logic [AW-1:0] r_cursor;
    logic          r_cursor_none;
    logic [1:0]    r_rs_status;
    logic [8:0]    r_rs_len;
    logic [3:0]    r_rs_row, r_rs_col;
    logic          r_rs_last;
    logic          r_o_valid;
    logic [1:0]    r_o_status;
    logic [8:0]    r_o_len;
    logic [3:0]    r_o_row, r_o_col;
    logic          r_o_last;

    // ---------------- shared combinational unit
    logic          accept, cfg_wr;
    logic          load_ok, seed_ok;
    logic [AW-1:0] cur_addr, start_addr, dest_addr;
    logic signed [SW-1:0] cr_s, cc_s, a_s, rlo, rhi, clo, chi;
    logic [RB:0]   b_r0, b_r1;
    logic [CB:0]   b_c0, b_c1;
    logic          win_empty;
    logic signed [RB+1:0] nr;
    logic signed [CB+1:0] nc;
    logic          nb_ok;
    logic [AW-1:0] nb_addr;
    logic [3:0]    li;
    logic signed [SW-1:0] wi, wj;
    logic signed [SW:0]   di, dj;
    logic signed [DW-1:0] wdist;
    logic          w_in;
    logic [CW:0]   rx_sum;
    logic [CW-1:0] rx_d;
    t_node         rx_new;
    logic          pk_better;
    logic          pd_grow, pd_fail;
    logic          pc_more, pr_more;
    logic [GW-1:0] n_guard;
    logic [8:0]    n_len_count, n_len_n;

    assign accept   = i_valid && o_ready;
    assign cfg_wr   = psel && penable && pwrite;
    assign load_ok  = (32'(i_cell_row) < GRID_ROWS) && (32'(i_cell_col) < GRID_COLS);
    assign seed_ok  = (32'(r_sr) < GRID_ROWS) && (32'(r_sc) < GRID_COLS)
                   && (32'(r_tr) < GRID_ROWS) && (32'(r_tc) < GRID_COLS);
    assign cur_addr   = {r_cur_r, r_cur_c};
    assign start_addr = {RB'(r_sr), CB'(r_sc)};
    assign dest_addr  = {r_dest_r, r_dest_c};
    assign n_guard    = r_guard + 1'b1;

    always_comb begin
        // window bounds around the current cell; a missing cell counts as -1
        cr_s = r_cur_none ? -SW'(1) : $signed(SW'(r_cur_r));
        cc_s = r_cur_none ? -SW'(1) : $signed(SW'(r_cur_c));
        a_s  = $signed(SW'(r_alpha));
        rlo  = cr_s - a_s;
        rhi  = cr_s + a_s;
        clo  = cc_s - a_s;
        chi  = cc_s + a_s;
        if (r_mode) begin
            b_r0 = (rlo < 0) ? '0 : (RB+1)'(rlo);
            b_r1 = (rhi < ROWS_S) ? (RB+1)'(rhi) : (RB+1)'(GRID_ROWS);
            b_c0 = (clo < 0) ? '0 : (CB+1)'(clo);
            b_c1 = (chi < COLS_S) ? (CB+1)'(chi) : (CB+1)'(GRID_COLS);
        end else begin
            b_r0 = '0;
            b_r1 = (RB+1)'(GRID_ROWS);
            b_c0 = '0;
            b_c1 = (CB+1)'(GRID_COLS);
        end
        win_empty = (b_r0 >= b_r1) || (b_c0 >= b_c1);

        // neighbour k of the current cell
        nr      = $signed((RB+2)'(r_cur_r)) + (RB+2)'(off_r(r_k));
        nc      = $signed((CB+2)'(r_cur_c)) + (CB+2)'(off_c(r_k));
        nb_ok   = (nr >= 0) && (nr < $signed((RB+2)'(GRID_ROWS)))
               && (nc >= 0) && (nc < $signed((CB+2)'(GRID_COLS)))
               && (r_k != 4'd4);
        nb_addr = {nr[RB-1:0], nc[CB-1:0]};

        // waypoint lattice point; step 0 measures the current cell itself
        li    = (r_k == 4'd0) ? 4'd4 : r_k - 4'd1;
        case (off_r(li))
            -2'sd1:  wi = cr_s - a_s;
            2'sd0:   wi = cr_s;
            default: wi = cr_s + a_s;
        endcase
        case (off_c(li))
            -2'sd1:  wj = cc_s - a_s;
            2'sd0:   wj = cc_s;
            default: wj = cc_s + a_s;
        endcase
        di    = (SW+1)'(wi) - $signed((SW+1)'(r_dest_r));
        dj    = (SW+1)'(wj) - $signed((SW+1)'(r_dest_c));
        wdist = DW'(di * di) + DW'(dj * dj);
        w_in  = (wi >= 0) && (wi < ROWS_S) && (wj >= 0) && (wj < COLS_S);

        // relaxation of one neighbour
        rx_sum = {1'b0, r_cc_cost} + {1'b0, (r_nb_diag ? COST_DIAG : COST_ONE)};
        rx_d   = (rx_sum > {1'b0, gdpp_pkg::COST_MAX}) ? gdpp_pkg::COST_MAX
                                                       : rx_sum[CW-1:0];
        rx_new = r_node_q;
        if (rx_d < r_node_q.cost) begin
            rx_new.cost = rx_d;
            if (r_cc_par != r_nb_addr) begin
                rx_new.par = cur_addr;
            end
        end
        if (r_node_q.st == gdpp_pkg::CS_UNV) begin
            rx_new.st = r_map_q ? gdpp_pkg::CS_BLK : gdpp_pkg::CS_FREE;
        end

        // minimum scan compare
        pk_better = (r_node_q.st == gdpp_pkg::CS_FREE) && (r_node_q.cost < r_best_cost);
        pc_more   = ((CB+1)'(r_pc) + 1'b1) < r_c1;
        pr_more   = ((RB+1)'(r_pr) + 1'b1) < r_r1;

        pd_grow = r_mode && r_best_none && (r_alpha < AL'(MAX_ALPHA));
        pd_fail = r_best_none || r_dest_blk;

        n_len_count = (32'(r_count) > 32'(gdpp_pkg::LEN_MAX)) ? gdpp_pkg::LEN_MAX
                                                              : 9'(r_count);
        n_len_n     = (32'(r_n) > 32'(gdpp_pkg::LEN_MAX)) ? gdpp_pkg::LEN_MAX
                                                          : 9'(r_n);
    end

    // memory port control
    always_comb begin
        node_we    = 1'b0;
        node_waddr = r_addr;
        node_wdata = '{st: gdpp_pkg::CS_UNV, cost: gdpp_pkg::COST_INF, par: r_addr};
        node_raddr = r_cursor;
        map_we     = 1'b0;
        map_waddr  = r_addr;
        map_wdata  = 1'b0;
        map_raddr  = nb_addr;
        case (r_state)
            S_MAPCLR: map_we = 1'b1;
            S_IDLE: begin
                if (accept && i_opcode == gdpp_pkg::OP_LOAD && load_ok) begin
                    map_we    = 1'b1;
                    map_waddr = {RB'(i_cell_row), CB'(i_cell_col)};
                    map_wdata = i_cell_blocked;
                end
            end
            S_PCLR: node_we = 1'b1;
            S_SEED: begin
                node_we    = seed_ok;
                node_waddr = start_addr;
                node_wdata = '{st: gdpp_pkg::CS_FREE, cost: '0, par: start_addr};
            end
            S_PICK: node_raddr = {r_pr, r_pc};
            S_PDONE: begin
                node_we    = !pd_grow && !pd_fail;
                node_waddr = r_best_addr;
                node_wdata = '{st: gdpp_pkg::CS_VIS, cost: r_best_cost, par: r_best_par};
            end
            S_EXRD: node_raddr = cur_addr;
            S_RISS: node_raddr = nb_addr;
            S_RWR: begin
                node_we    = 1'b1;
                node_waddr = r_nb_addr;
                node_wdata = rx_new;
            end
            S_BTRD: node_raddr = r_x;
            default: ;
        endcase
    end

    // ---------------- sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_MAPCLR;
            r_addr        <= '0;
            r_mode        <= 1'b0;
            r_wstart      <= 5'd5;
            r_wstep       <= 5'd5;
            r_o_valid     <= 1'b0;
            r_cursor_none <= 1'b1;
            r_left        <= '0;
            r_count       <= '0;
        end else begin
            // configuration writes land whenever the port completes one
            if (cfg_wr) begin
                unique case (paddr[3:2])
                    gdpp_pkg::REG_MODE:   r_mode   <= pwdata[0];
                    gdpp_pkg::REG_WSTART: r_wstart <= pwdata[4:0];
                    gdpp_pkg::REG_WSTEP:  r_wstep  <= pwdata[4:0];
                    default: ;
                endcase
            end
            if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end

            unique case (r_state)
                S_MAPCLR: begin
                    // sweep the obstacle map to free after reset
                    r_addr <= r_addr + 1'b1;
                    if (&r_addr) begin
                        r_state <= S_IDLE;
                    end
                end

                S_IDLE: begin
                    if (accept) begin
                        r_rs_status <= gdpp_pkg::RS_OK;
                        r_rs_len    <= '0;
                        r_rs_row    <= '0;
                        r_rs_col    <= '0;
                        r_rs_last   <= 1'b0;
                        r_state     <= S_RESP;
                        case (i_opcode)
                            gdpp_pkg::OP_PLAN: begin
                                r_sr          <= i_start_row;
                                r_sc          <= i_start_col;
                                r_tr          <= i_dest_row;
                                r_tc          <= i_dest_col;
                                r_count       <= '0;
                                r_left        <= '0;
                                r_cursor_none <= 1'b1;
                                r_addr        <= '0;
                                r_state       <= S_PCLR;
                            end
                            gdpp_pkg::OP_READ: begin
                                r_rs_len <= n_len_count;
                                if (r_cursor_none || r_left == '0) begin
                                    r_rs_status <= gdpp_pkg::RS_EXHAUSTED;
                                end else begin
                                    r_rs_row <= 4'(r_cursor[AW-1:CB]);
                                    r_rs_col <= 4'(r_cursor[CB-1:0]);
                                    r_left   <= r_left - 1'b1;
                                    if (r_left == CNTW'(1)) begin
                                        r_rs_last     <= 1'b1;
                                        r_cursor_none <= 1'b1;
                                    end else begin
                                        // parent of the cursor is in flight
                                        r_state <= S_RDWT;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end

                S_RDWT: begin
                    r_cursor <= r_node_q.par;
                    r_state  <= S_RESP;
                end

                S_PCLR: begin
                    r_addr <= r_addr + 1'b1;
                    if (&r_addr) begin
                        r_state <= S_SEED;
                    end
                end

                S_SEED: begin
                    r_cur_r     <= RB'(r_sr);
                    r_cur_c     <= CB'(r_sc);
                    r_cur_none  <= 1'b0;
                    r_dest_r    <= RB'(r_tr);
                    r_dest_c    <= CB'(r_tc);
                    r_dest_blk  <= 1'b0;
                    r_found     <= 1'b0;
                    r_seg_end   <= 1'b0;
                    r_alpha     <= (r_wstart == '0) ? AL'(1) : AL'(r_wstart);
                    r_step      <= (r_wstep == '0) ? 5'd1 : r_wstep;
                    r_guard     <= '0;
                    r_k         <= '0;
                    if (!seed_ok) begin
                        r_rs_status <= gdpp_pkg::RS_NOPATH;
                        r_state     <= S_RESP;
                    end else begin
                        r_state <= r_mode ? S_WP : S_PINIT;
                    end
                end

                S_WP: begin
                    // step 0 measures the current cell, then nine lattice points
                    if (r_k == 4'd0) begin
                        r_wbest  <= wdist;
                        r_wmoved <= 1'b0;
                    end else if (w_in && wdist < r_wbest) begin
                        r_wbest  <= wdist;
                        r_wres   <= {wi[RB-1:0], wj[CB-1:0]};
                        r_wmoved <= 1'b1;
                    end
                    r_k <= r_k + 1'b1;
                    if (r_k == 4'd9) begin
                        r_wp    <= r_wmoved ? r_wres : dest_addr;
                        r_state <= S_PINIT;
                    end
                end

                S_PINIT: begin
                    r_guard     <= n_guard;
                    r_r0        <= b_r0;
                    r_r1        <= b_r1;
                    r_c0        <= b_c0;
                    r_c1        <= b_c1;
                    r_pr        <= RB'(b_r0);
                    r_pc        <= CB'(b_c0);
                    r_pk_v      <= 1'b0;
                    r_best_none <= 1'b1;
                    r_best_cost <= gdpp_pkg::COST_INF;
                    if (r_mode && 32'(n_guard) > LIMIT) begin
                        r_rs_status <= gdpp_pkg::RS_NOPATH;
                        r_state     <= S_RESP;
                    end else begin
                        r_state <= win_empty ? S_PDONE : S_PICK;
                    end
                end

                S_PICK: begin
                    // issue one read a cycle, compare the one issued before
                    if (r_pk_v && pk_better) begin
                        r_best_none <= 1'b0;
                        r_best_addr <= r_pk_addr;
                        r_best_cost <= r_node_q.cost;
                        r_best_par  <= r_node_q.par;
                    end
                    r_pk_v    <= 1'b1;
                    r_pk_addr <= {r_pr, r_pc};
                    if (pc_more) begin
                        r_pc <= r_pc + 1'b1;
                    end else begin
                        r_pc <= CB'(r_c0);
                        if (pr_more) begin
                            r_pr <= r_pr + 1'b1;
                        end else begin
                            r_state <= S_PLAST;
                        end
                    end
                end

                S_PLAST: begin
                    if (pk_better) begin
                        r_best_none <= 1'b0;
                        r_best_addr <= r_pk_addr;
                        r_best_cost <= r_node_q.cost;
                        r_best_par  <= r_node_q.par;
                    end
                    r_state <= S_PDONE;
                end

                S_PDONE: begin
                    r_cur_none <= r_best_none;
                    r_cur_r    <= r_best_addr[AW-1:CB];
                    r_cur_c    <= r_best_addr[CB-1:0];
                    if (pd_grow) begin
                        // empty window: widen and scan again
                        r_alpha <= r_alpha + AL'(r_step);
                        r_state <= S_PINIT;
                    end else if (pd_fail) begin
                        r_rs_status <= gdpp_pkg::RS_NOPATH;
                        r_state     <= S_RESP;
                    end else if (!r_mode && r_best_addr == dest_addr) begin
                        r_x     <= dest_addr;
                        r_n     <= CNTW'(1);
                        r_state <= S_BTRD;
                    end else begin
                        r_found   <= (r_best_addr == dest_addr);
                        r_seg_end <= (r_best_addr == dest_addr) || (r_best_addr == r_wp);
                        r_state   <= S_EXRD;
                    end
                end

                S_EXRD: r_state <= S_EXCAP;

                S_EXCAP: begin
                    r_cc_cost <= r_node_q.cost;
                    r_cc_par  <= r_node_q.par;
                    r_k       <= '0;
                    r_state   <= S_RISS;
                end

                S_RISS: begin
                    if (r_k == 4'd9) begin
                        r_k <= '0;
                        if (!r_mode) begin
                            r_state <= S_PINIT;
                        end else if (r_found) begin
                            r_x     <= dest_addr;
                            r_n     <= CNTW'(1);
                            r_state <= S_BTRD;
                        end else if (r_seg_end) begin
                            r_seg_end <= 1'b0;
                            r_state   <= S_WP;
                        end else begin
                            r_state <= S_PINIT;
                        end
                    end else if (nb_ok) begin
                        r_nb_addr <= nb_addr;
                        r_nb_diag <= (off_r(r_k) != 2'sd0) && (off_c(r_k) != 2'sd0);
                        r_state   <= S_RWR;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end

                S_RWR: begin
                    if (r_nb_addr == dest_addr && rx_new.st == gdpp_pkg::CS_BLK) begin
                        r_dest_blk <= 1'b1;
                    end
                    r_k     <= r_k + 1'b1;
                    r_state <= S_RISS;
                end

                S_BTRD: r_state <= S_BTCHK;

                S_BTCHK: begin
                    // follow parents back to the start
                    if (r_node_q.par != r_x && 32'(r_n) < NCELLS) begin
                        r_x     <= r_node_q.par;
                        r_n     <= r_n + 1'b1;
                        r_state <= S_BTRD;
                    end else begin
                        r_count       <= r_n;
                        r_left        <= r_n;
                        r_cursor      <= dest_addr;
                        r_cursor_none <= 1'b0;
                        r_rs_status   <= gdpp_pkg::RS_OK;
                        r_rs_len      <= n_len_n;
                        r_state       <= S_RESP;
                    end
                end

                S_RESP: begin
                    // hold until the result register is free
                    if (!r_o_valid || i_ready) begin
                        r_o_valid  <= 1'b1;
                        r_o_status <= r_rs_status;
                        r_o_len    <= r_rs_len;
                        r_o_row    <= r_rs_row;
                        r_o_col    <= r_rs_col;
                        r_o_last   <= r_rs_last;
                        r_state    <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            gdpp_pkg::REG_MODE:   prdata = {31'd0, r_mode};
            gdpp_pkg::REG_WSTART: prdata = {27'd0, r_wstart};
            gdpp_pkg::REG_WSTEP:  prdata = {27'd0, r_wstep};
            default:              prdata = '0;
        endcase
    end

    assign pready        = 1'b1;
    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_o_valid;
    assign o_status      = r_o_status;
    assign o_path_length = r_o_len;
    assign o_out_row     = r_o_row;
    assign o_out_col     = r_o_col;
    assign o_last_cell   = r_o_last;

endmodule
`default_nettype wire

// ----- tb/tb_grid_dijkstra_path_planner_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb_grid_dijkstra_path_planner_unit: self-checking bench for the grid planner
// Drives load, plan and read beats with random gaps and result stalls, runs a
// behavioural Dijkstra planner alongside the block, and compares every result
// beat field by field. Register settings change between idle phases.
// ----------------------------------------------------------------------------
module tb_grid_dijkstra_path_planner_unit;
    import gdpp_pkg::*;

    localparam int ROWS      = 16;
    localparam int COLS      = 16;
    localparam int NODES     = ROWS * COLS;
    localparam int STEP_COST = 256;         // 1.0 with 8 fraction bits
    localparam int DIAG_COST = 362;         // 362/256 with 8 fraction bits
    localparam int MAX_WIN   = 16;
    localparam logic [1:0] OP_NONE = 2'd3;  // unused opcode, answers zeros
    localparam int STALL_LIMIT = 400000;    // cycles without any beat
    localparam int RX_HOLD     = 400;       // long result back-pressure

    typedef struct packed {
        logic [1:0] opcode;
        logic [3:0] cell_row;
        logic [3:0] cell_col;
        logic       cell_blocked;
        logic [3:0] start_row;
        logic [3:0] start_col;
        logic [3:0] dest_row;
        logic [3:0] dest_col;
    } cmd_t;

    typedef struct packed {
        logic [1:0] status;
        logic [8:0] path_length;
        logic [3:0] out_row;
        logic [3:0] out_col;
        logic       last_cell;
    } res_t;

    typedef struct packed {
        cmd_t cmd;
        logic typed;    // use the hand-written answer below
        res_t answer;
    } row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_opcode = '0;
    logic [3:0]  i_cell_row = '0;
    logic [3:0]  i_cell_col = '0;
    logic        i_cell_blocked = 1'b0;
    logic [3:0]  i_start_row = '0;
    logic [3:0]  i_start_col = '0;
    logic [3:0]  i_dest_row = '0;
    logic [3:0]  i_dest_col = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_status;
    logic [8:0]  o_path_length;
    logic [3:0]  o_out_row;
    logic [3:0]  o_out_col;
    logic        o_last_cell;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    grid_dijkstra_path_planner_unit u_dut (
        .i_clk, .i_rst_n,
        .i_valid, .o_ready, .i_opcode, .i_cell_row, .i_cell_col, .i_cell_blocked,
        .i_start_row, .i_start_col, .i_dest_row, .i_dest_col,
        .o_valid, .i_ready, .o_status, .o_path_length, .o_out_row, .o_out_col,
        .o_last_cell,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Planner shadow: obstacle map, search state and register copies
    // ------------------------------------------------------------------------
    logic              occ_map   [NODES];
    logic [1:0]        node_state[NODES];
    logic [COST_W-1:0] node_cost [NODES];
    int                node_parent[NODES];
    int                cur_node, dest_node, waypoint, win_size;
    int                path_cells, read_pos, reads_left;
    logic              mode_reg;
    logic [4:0]        wstart_reg, wstep_reg;

    res_t expected_results[$];
    int   fail_count = 0;
    int   rx_beats = 0;
    int   idle_cycles = 0;

    function automatic int row_of(int x);
        return x < 0 ? -1 : x / COLS;
    endfunction

    function automatic int col_of(int x);
        return x < 0 ? -1 : x % COLS;
    endfunction

    function automatic void relax_node(int r, int c);
        int ci;
        int d;
        bit diag;
        ci = r * COLS + c;
        diag = (r != row_of(cur_node)) && (c != col_of(cur_node));
        d = int'(node_cost[cur_node]) + (diag ? DIAG_COST : STEP_COST);
        if (d > int'(COST_MAX)) d = int'(COST_MAX);
        if (d < int'(node_cost[ci])) begin
            node_cost[ci] = d[COST_W-1:0];
            if (node_parent[cur_node] != ci) node_parent[ci] = cur_node;
        end
        if (node_state[ci] == CS_UNV) node_state[ci] = occ_map[ci] ? CS_BLK : CS_FREE;
    endfunction

    function automatic void expand_node();
        int r;
        int c;
        if (cur_node < 0) return;
        for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
                r = row_of(cur_node) + dr;
                c = col_of(cur_node) + dc;
                if ((dr != 0 || dc != 0) && r >= 0 && r < ROWS && c >= 0 && c < COLS)
                    relax_node(r, c);
            end
        end
    endfunction

    // Cheapest open cell in rows r0..r1-1, columns c0..c1-1; ties keep the first
    function automatic int cheapest_open(int r0, int r1, int c0, int c1);
        int best;
        int at;
        best = int'(COST_INF);
        at = -1;
        for (int r = r0; r < r1; r++) begin
            for (int c = c0; c < c1; c++) begin
                if (node_state[r*COLS+c] == CS_FREE && int'(node_cost[r*COLS+c]) < best) begin
                    best = node_cost[r*COLS+c];
                    at = r * COLS + c;
                end
            end
        end
        return at;
    endfunction

    function automatic bit stuck_search();
        return cur_node < 0 || node_state[dest_node] == CS_BLK;
    endfunction

    function automatic int next_waypoint(int a);
        int cr, cc, tr, tc, best, res, d;
        bit moved;
        cr = row_of(cur_node);
        cc = col_of(cur_node);
        tr = row_of(dest_node);
        tc = col_of(dest_node);
        best = (cr - tr) * (cr - tr) + (cc - tc) * (cc - tc);
        res = cur_node;
        moved = 1'b0;
        for (int i = cr - a; i <= cr + a; i += a) begin
            for (int j = cc - a; j <= cc + a; j += a) begin
                if (i >= 0 && j >= 0 && i < ROWS && j < COLS) begin
                    d = (i - tr) * (i - tr) + (j - tc) * (j - tc);
                    if (d < best) begin
                        best = d;
                        res = i * COLS + j;
                        moved = 1'b1;
                    end
                end
            end
        end
        return moved ? res : dest_node;
    endfunction

    function automatic bit search_whole_grid();
        for (int n = 0; n <= NODES; n++) begin
            cur_node = cheapest_open(0, ROWS, 0, COLS);
            if (stuck_search()) return 1'b0;
            node_state[cur_node] = CS_VIS;
            if (cur_node == dest_node) return 1'b1;
            expand_node();
        end
        return 1'b0;
    endfunction

    function automatic bit search_windowed();
        int a, grow, guard, cap, cr, cc, r0, r1, c0, c1;
        bit found, stuck;
        a = (wstart_reg != 0) ? int'(wstart_reg) : 1;
        grow = (wstep_reg != 0) ? int'(wstep_reg) : 1;
        guard = 0;
        cap = 2 * NODES + 2 * MAX_WIN + 4;
        found = 1'b0;
        stuck = 1'b0;
        win_size = a;
        while (!found) begin
            waypoint = next_waypoint(a);
            forever begin
                cr = row_of(cur_node);
                cc = col_of(cur_node);
                r0 = (cr - a < 0) ? 0 : cr - a;
                r1 = (cr + a < ROWS) ? cr + a : ROWS;
                c0 = (cc - a < 0) ? 0 : cc - a;
                c1 = (cc + a < COLS) ? cc + a : COLS;
                guard++;
                if (guard > cap) begin
                    stuck = 1'b1;
                    break;
                end
                cur_node = cheapest_open(r0, r1, c0, c1);
                if (cur_node < 0 && a < MAX_WIN) begin
                    a += grow;
                    win_size = a;
                    continue;
                end
                if (stuck_search()) break;
                node_state[cur_node] = CS_VIS;
                found = (cur_node == dest_node);
                if (found || cur_node == waypoint) break;
                expand_node();
            end
            if (stuck || stuck_search()) break;
            expand_node();
        end
        return found && !stuck;
    endfunction

    function automatic void clear_planner();
        for (int i = 0; i < NODES; i++) begin
            occ_map[i] = 1'b0;
            node_state[i] = CS_UNV;
            node_cost[i] = COST_INF;
            node_parent[i] = i;
        end
        cur_node = -1;
        dest_node = 0;
        waypoint = 0;
        win_size = 0;
        path_cells = 0;
        read_pos = -1;
        reads_left = 0;
        mode_reg = 1'b0;
        wstart_reg = 5'd5;
        wstep_reg = 5'd5;
    endfunction

    // Advance the shadow by one command beat and return the answer it owes
    function automatic res_t predict_answer(cmd_t c);
        res_t o;
        bit found;
        int x, n;
        o = '0;
        case (c.opcode)
            OP_LOAD: begin
                occ_map[c.cell_row * COLS + c.cell_col] = c.cell_blocked;
            end
            OP_PLAN: begin
                for (int i = 0; i < NODES; i++) begin
                    node_state[i] = CS_UNV;
                    node_cost[i] = COST_INF;
                    node_parent[i] = i;
                end
                path_cells = 0;
                read_pos = -1;
                reads_left = 0;
                cur_node = c.start_row * COLS + c.start_col;
                dest_node = c.dest_row * COLS + c.dest_col;
                // the start is searched as free even when blocked
                node_state[cur_node] = CS_FREE;
                node_cost[cur_node] = '0;
                found = mode_reg ? search_windowed() : search_whole_grid();
                if (found) begin
                    x = dest_node;
                    n = 1;
                    while (node_parent[x] != x && n < NODES) begin
                        x = node_parent[x];
                        n++;
                    end
                    path_cells = n;
                    read_pos = dest_node;
                    reads_left = n;
                end
                o.status = found ? RS_OK : RS_NOPATH;
                o.path_length = path_cells[8:0];
            end
            OP_READ: begin
                o.path_length = path_cells[8:0];
                if (read_pos < 0 || reads_left == 0) begin
                    o.status = RS_EXHAUSTED;
                end else begin
                    o.out_row = row_of(read_pos);
                    o.out_col = col_of(read_pos);
                    reads_left--;
                    if (reads_left == 0) begin
                        o.last_cell = 1'b1;
                        read_pos = -1;
                    end else begin
                        read_pos = node_parent[read_pos];
                    end
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    // ------------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------------
    bit tx_calm = 1'b0;
    int tx_beats = 0;

    // Drop valid over gaps; keep it high across back-to-back beats
    task automatic send_beat(cmd_t c, res_t forced, bit use_forced);
        int gap;
        res_t r;
        if (tx_beats % 16 == 0) tx_calm = ($urandom_range(0, 3) == 0);
        gap = tx_calm ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_opcode       <= c.opcode;
        i_cell_row     <= c.cell_row;
        i_cell_col     <= c.cell_col;
        i_cell_blocked <= c.cell_blocked;
        i_start_row    <= c.start_row;
        i_start_col    <= c.start_col;
        i_dest_row     <= c.dest_row;
        i_dest_col     <= c.dest_col;
        do @(posedge i_clk); while (!o_ready);
        r = predict_answer(c);
        expected_results.push_back(use_forced ? forced : r);
        tx_beats++;
    endtask

    function automatic cmd_t mk_cmd(logic [1:0] op, int cr, int cc, bit cb,
                                    int sr, int sc, int dr, int dc);
        cmd_t c;
        c.opcode = op;
        c.cell_row = cr;
        c.cell_col = cc;
        c.cell_blocked = cb;
        c.start_row = sr;
        c.start_col = sc;
        c.dest_row = dr;
        c.dest_col = dc;
        return c;
    endfunction

    function automatic res_t mk_res(logic [1:0] st, int len, int r, int c, bit last);
        res_t o;
        o.status = st;
        o.path_length = len;
        o.out_row = r;
        o.out_col = c;
        o.last_cell = last;
        return o;
    endfunction

    function automatic cmd_t random_cmd(logic [1:0] op);
        cmd_t c;
        c = $urandom;
        c.opcode = op;
        return c;
    endfunction

    // Drain, let the block settle, then write one register over APB
    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MODE:   mode_reg = value[0];
            REG_WSTART: wstart_reg = value[4:0];
            REG_WSTEP:  wstep_reg = value[4:0];
            default: ;
        endcase
    endtask

    task automatic set_mode(bit m, int ws, int st);
        write_reg(REG_MODE, m);
        write_reg(REG_WSTART, ws);
        write_reg(REG_WSTEP, st);
    endtask

    // Rounds of map edits, one plan, then reads down the path; a little noise mixed in
    task automatic random_burst(int items);
        int sent, loads, reads;
        cmd_t c;
        sent = 0;
        while (sent < items) begin
            loads = $urandom_range(2, 8);
            repeat (loads) begin
                c = random_cmd(OP_LOAD);
                c.cell_blocked = ($urandom_range(0, 2) == 0);
                send_beat(c, '0, 1'b0);
                sent++;
            end
            if ($urandom_range(0, 7) == 0) begin
                send_beat(random_cmd($urandom_range(0, 1) ? OP_NONE : OP_READ), '0, 1'b0);
                sent++;
            end
            send_beat(random_cmd(OP_PLAN), '0, 1'b0);
            sent++;
            reads = (path_cells > 11) ? 12 : path_cells + 1;
            reads = $urandom_range(1, reads);
            repeat (reads) begin
                send_beat(random_cmd(OP_READ), '0, 1'b0);
                sent++;
            end
        end
    endtask

    row_t directed[$];

    initial begin
        clear_planner();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows: typed answers only where plain to see
        directed.push_back({mk_cmd(OP_NONE, 15, 15, 1, 15, 15, 15, 15), 1'b1,
                            mk_res(RS_OK, 0, 0, 0, 0)});
        directed.push_back({mk_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                            mk_res(RS_EXHAUSTED, 0, 0, 0, 0)});
        directed.push_back({mk_cmd(OP_LOAD, 15, 15, 1, 0, 0, 0, 0), 1'b1, res_t'('0)});
        directed.push_back({mk_cmd(OP_LOAD, 0, 0, 0, 15, 15, 15, 15), 1'b1, res_t'('0)});
        directed.push_back({mk_cmd(OP_PLAN, 0, 0, 0, 3, 3, 3, 3), 1'b1,
                            mk_res(RS_OK, 1, 0, 0, 0)});
        directed.push_back({mk_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                            mk_res(RS_OK, 1, 3, 3, 1)});
        directed.push_back({mk_cmd(OP_READ, 15, 15, 1, 15, 15, 15, 15), 1'b1,
                            mk_res(RS_EXHAUSTED, 1, 0, 0, 0)});
        directed.push_back({mk_cmd(OP_LOAD, 5, 6, 1, 0, 0, 0, 0), 1'b1, res_t'('0)});
        // destination blocked next to the start
        directed.push_back({mk_cmd(OP_PLAN, 0, 0, 0, 5, 5, 5, 6), 1'b1,
                            mk_res(RS_NOPATH, 0, 0, 0, 0)});
        directed.push_back({mk_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                            mk_res(RS_EXHAUSTED, 0, 0, 0, 0)});
        directed.push_back({mk_cmd(OP_PLAN, 0, 0, 0, 0, 0, 15, 15), 1'b0, res_t'('0)});
        directed.push_back({mk_cmd(OP_LOAD, 15, 15, 0, 0, 0, 0, 0), 1'b0, res_t'('0)});
        directed.push_back({mk_cmd(OP_PLAN, 0, 0, 0, 0, 0, 15, 15), 1'b0, res_t'('0)});
        directed.push_back({mk_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0), 1'b0, res_t'('0)});
        directed.push_back({mk_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0), 1'b0, res_t'('0)});
        // blocked start is searched as free
        directed.push_back({mk_cmd(OP_LOAD, 8, 8, 1, 0, 0, 0, 0), 1'b0, res_t'('0)});
        directed.push_back({mk_cmd(OP_PLAN, 0, 0, 0, 8, 8, 10, 10), 1'b0, res_t'('0)});
        for (int k = 0; k < 4; k++)
            directed.push_back({mk_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0), 1'b0, res_t'('0)});
        directed.push_back({mk_cmd(OP_PLAN, 0, 0, 0, 15, 0, 0, 15), 1'b0, res_t'('0)});
        directed.push_back({mk_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0), 1'b0, res_t'('0)});

        foreach (directed[k]) send_beat(directed[k].cmd, directed[k].answer, directed[k].typed);

        random_burst(20);
        set_mode(1'b1, 1, 1);
        random_burst(18);
        set_mode(1'b1, 16, 16);
        random_burst(18);
        set_mode(1'b1, 0, 31);      // zero start acts as one, widest step
        random_burst(16);
        set_mode(1'b1, 3, 2);
        random_burst(16);
        write_reg(REG_MODE, 0);
        random_burst(10);

        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: random stalls, calm stretches, and one long hold-off
    // ------------------------------------------------------------------------
    initial begin : rx_driver
        int wait_cycles;
        bit calm;
        bit held;
        calm = 1'b0;
        held = 1'b0;
        @(posedge i_clk);
        forever begin
            if (rx_beats % 16 == 0) calm = ($urandom_range(0, 3) == 0);
            wait_cycles = calm ? 0 : $urandom_range(0, 14);
            if (!held && rx_beats == 40) begin
                held = 1'b1;
                wait_cycles = RX_HOLD;
            end
            if (wait_cycles > 0) begin
                i_ready <= 1'b0;
                repeat (wait_cycles) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // Compare each result beat with the oldest answer owed
    always @(posedge i_clk) begin
        res_t got;
        res_t exp_r;
        if (i_rst_n && o_valid && i_ready) begin
            rx_beats <= rx_beats + 1;
            got = {o_status, o_path_length, o_out_row, o_out_col, o_last_cell};
            if (expected_results.size() == 0) begin
                fail_count <= fail_count + 1;
                $display("%0t: unexpected result beat st=%0d len=%0d r=%0d c=%0d last=%0d",
                         $time, got.status, got.path_length, got.out_row, got.out_col,
                         got.last_cell);
            end else begin
                exp_r = expected_results.pop_front();
                if (got.status !== exp_r.status || got.path_length !== exp_r.path_length ||
                    got.out_row !== exp_r.out_row || got.out_col !== exp_r.out_col ||
                    got.last_cell !== exp_r.last_cell) begin
                    fail_count <= fail_count + 1;
                    $display("%0t: mismatch exp st=%0d len=%0d r=%0d c=%0d last=%0d",
                             $time, exp_r.status, exp_r.path_length, exp_r.out_row,
                             exp_r.out_col, exp_r.last_cell);
                    $display("%0t:          got st=%0d len=%0d r=%0d c=%0d last=%0d",
                             $time, got.status, got.path_length, got.out_row,
                             got.out_col, got.last_cell);
                end
            end
        end
    end

    // Watchdog: count cycles with no beat on the command, result or config channel
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || psel) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
`default_nettype wire
